[rtl/static_huffman_byte_decoder_core_macros.svh]
// ----------------------------------------------------------------------------
// Static Huffman byte decoder - assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef STATIC_HUFFMAN_BYTE_DECODER_CORE_MACROS_SVH
`define STATIC_HUFFMAN_BYTE_DECODER_CORE_MACROS_SVH

// Property checked at every clock edge.
`define SHBD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SHBD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/shbd_pkg.sv]
// ----------------------------------------------------------------------------
// shbd_pkg
// Types, constants and the code ROM of the static Huffman byte decoder.
// ----------------------------------------------------------------------------
package shbd_pkg;

  localparam int MinCodeBits    = 2;
  localparam int MaxCodeBits    = 11;
  localparam int WindowBits     = 18;
  localparam int ResultCap      = 10;
  localparam int HeldW          = $clog2(WindowBits + 1);
  localparam int LenW           = $clog2(MaxCodeBits + 1);
  localparam int CountW         = $clog2(ResultCap + 1);
  localparam int AddrW          = 3;
  localparam logic [7:0] EndMarkerReset = 8'd4;
  localparam logic [AddrW-3:0] RegEndMarker = '0;

  typedef enum logic [1:0] {
    StatusSymbol  = 2'd0,
    StatusEnd     = 2'd1,
    StatusInvalid = 2'd2
  } status_e;

  // Outcome of one match attempt on the window.
  typedef enum logic [1:0] {
    KindPause   = 2'd0,
    KindHit     = 2'd1,
    KindInvalid = 2'd2
  } kind_e;

  typedef struct packed {
    logic load;    // take the accepted byte into the window
    logic step;    // commit the current match result
    logic finish;  // close the run, release last beat
  } dp_cmd_t;

  typedef struct packed {
    logic  ended;
    logic  cap_hit;
    kind_e kind;
    logic  pend_valid;
    logic  out_free;
  } dp_status_t;

  typedef struct packed {
    logic       hit;
    logic       is_end;
    logic [7:0] sym;
  } rom_entry_t;

  function automatic rom_entry_t sym_hit(input logic [7:0] sym);
    rom_entry_t e;
    e.hit    = 1'b1;
    e.is_end = 1'b0;
    e.sym    = sym;
    return e;
  endfunction

  // Code ROM: code bits right aligned, looked up by length.
  function automatic rom_entry_t rom_lookup(input logic [LenW-1:0] len,
                                            input logic [MaxCodeBits-1:0] code);
    rom_entry_t e;
    e = '0;
    unique case (len)
      LenW'(2): begin
        unique case (code)
          11'h000: e = sym_hit(" ");
          11'h002: e = sym_hit("0");
          default: e = '0;
        endcase
      end
      LenW'(5): begin
        unique case (code)
          11'h01A: e = sym_hit(8'h0D);
          11'h01B: e = sym_hit(8'h0A);
          11'h00B: e = sym_hit("i");
          default: e = '0;
        endcase
      end
      LenW'(6): begin
        unique case (code)
          11'h010: e = sym_hit("p");
          11'h011: e = sym_hit("r");
          11'h014: e = sym_hit("E");
          11'h01C: e = sym_hit("1");
          11'h01E: e = sym_hit("m");
          11'h01F: e = sym_hit("a");
          11'h030: e = sym_hit("t");
          11'h031: e = sym_hit("o");
          11'h032: e = sym_hit("e");
          11'h03F: e = sym_hit("d");
          11'h03D: e = sym_hit("n");
          default: e = '0;
        endcase
      end
      LenW'(7): begin
        unique case (code)
          11'h074: e = sym_hit(">");
          11'h075: e = sym_hit("l");
          11'h076: e = sym_hit("I");
          11'h077: e = sym_hit("u");
          11'h073: e = sym_hit("4");
          11'h071: e = sym_hit("C");
          11'h079: e = sym_hit("_");
          11'h030: e = sym_hit("9");
          11'h031: e = sym_hit("D");
          11'h02A: e = sym_hit("2");
          11'h02B: e = sym_hit("A");
          11'h033: e = sym_hit("T");
          11'h034: e = sym_hit("f");
          11'h035: e = sym_hit("s");
          11'h037: e = sym_hit("M");
          11'h03B: e = sym_hit("3");
          default: e = '0;
        endcase
      end
      LenW'(8): begin
        unique case (code)
          11'h0FB: e = sym_hit(":");
          11'h0F8: e = sym_hit("h");
          11'h0F9: e = sym_hit("8");
          11'h0E0: e = sym_hit("N");
          11'h0E1: e = sym_hit("R");
          11'h0E4: e = sym_hit("B");
          11'h0E5: e = sym_hit("v");
          11'h0F0: e = sym_hit("c");
          11'h049: e = sym_hit("H");
          11'h04C: e = sym_hit("G");
          11'h04D: e = sym_hit("y");
          11'h04E: e = sym_hit("L");
          11'h04F: e = sym_hit("x");
          11'h064: e = sym_hit("w");
          11'h065: e = sym_hit("U");
          11'h06C: e = sym_hit("S");
          11'h06D: e = sym_hit("b");
          11'h074: e = sym_hit("5");
          11'h0CC: e = sym_hit("z");
          11'h0CD: e = sym_hit("P");
          11'h0CF: e = sym_hit("O");
          default: e = '0;
        endcase
      end
      LenW'(9): begin
        unique case (code)
          11'h090: e = sym_hit("Z");
          11'h091: e = sym_hit("Y");
          11'h094: e = sym_hit("Q");
          11'h095: e = sym_hit("K");
          11'h096: e = sym_hit("X");
          11'h097: e = sym_hit("W");
          11'h0EA: e = sym_hit("7");
          11'h0EB: e = sym_hit("k");
          11'h19D: e = sym_hit("V");
          11'h1E2: e = sym_hit("j");
          11'h1E3: e = sym_hit("F");
          default: e = '0;
        endcase
      end
      LenW'(10): begin
        unique case (code)
          11'h3E8: e = sym_hit("g");
          11'h3E9: e = sym_hit("6");
          11'h3EA: e = sym_hit("J");
          11'h3EB: e = sym_hit("q");
          11'h338: e = sym_hit("-");
          default: e = '0;
        endcase
      end
      LenW'(11): begin
        unique case (code)
          11'h672: e = sym_hit(".");
          11'h673: begin
            e.hit    = 1'b1;
            e.is_end = 1'b1;
            e.sym    = 8'h00;
          end
          default: e = '0;
        endcase
      end
      default: e = '0;
    endcase
    return e;
  endfunction

endpackage

[rtl/shbd_ctrl.sv]
// ----------------------------------------------------------------------------
// shbd_ctrl
// Sequencer: takes a byte, steps the match unit, closes the run.
// ----------------------------------------------------------------------------
module shbd_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  shbd_pkg::dp_status_t status_i,
  output logic                 in_stall_o,
  output shbd_pkg::dp_cmd_t    cmd_o
);
  import shbd_pkg::*;

  typedef enum logic [1:0] {
    StIdle  = 2'b01,
    StMatch = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   can_move;
  logic   more;

  // a pending beat may only move when the output register is free
  assign can_move = !status_i.pend_valid || status_i.out_free;
  assign more     = !status_i.ended && !status_i.cap_hit && (status_i.kind != KindPause);

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StMatch;
        end
      end
      StMatch: begin
        if (can_move) begin
          if (more) begin
            cmd_o.step = 1'b1;
          end else begin
            cmd_o.finish = 1'b1;
            state_d      = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/shbd_dp.sv]
// ----------------------------------------------------------------------------
// shbd_dp
// Bit window, code match unit, pending beat and output register.
// ----------------------------------------------------------------------------
`include "static_huffman_byte_decoder_core_macros.svh"

module shbd_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  shbd_pkg::dp_cmd_t    cmd_i,
  input  logic [7:0]           in_byte_i,
  input  logic                 final_byte_i,
  input  logic [7:0]           end_marker_i,
  input  logic                 out_stall_i,
  output shbd_pkg::dp_status_t status_o,
  output logic                 out_valid_o,
  output logic [7:0]           symbol_o,
  output logic [1:0]           status_out_o,
  output logic                 last_of_run_o
);
  import shbd_pkg::*;

  logic [WindowBits-1:0] window_q, window_d;
  logic [HeldW-1:0]      held_q, held_d;
  logic                  ended_q, ended_d;
  logic                  final_q;
  logic [CountW-1:0]     count_q;
  logic                  pend_valid_q, pend_valid_d;
  logic [7:0]            pend_sym_q;
  status_e               pend_status_q;
  logic                  out_valid_q;
  logic [7:0]            out_sym_q;
  status_e               out_status_q;
  logic                  out_last_q;

  logic [WindowBits-1:0] aligned;
  rom_entry_t            entry_arr [MinCodeBits:MaxCodeBits];
  logic [MaxCodeBits:MinCodeBits] avail;
  rom_entry_t            sel;
  logic [LenW-1:0]       sel_len;
  logic                  any_hit;
  kind_e                 kind;
  logic [HeldW-1:0]      rem_held;
  logic [WindowBits-1:0] keep_mask;
  logic                  out_free;
  logic                  out_push;
  logic                  push_last;
  logic [7:0]            new_sym;
  status_e               new_status;

  // left-align the window so every code length reads from the top bits
  assign aligned = window_q << (HeldW'(WindowBits) - held_q);

  for (genvar g = MinCodeBits; g <= MaxCodeBits; g++) begin : g_len
    assign entry_arr[g] = rom_lookup(LenW'(g), MaxCodeBits'(aligned[WindowBits-1 -: g]));
    assign avail[g]     = held_q >= HeldW'(g);
  end

  // shortest available match wins
  always_comb begin
    sel     = '0;
    sel_len = '0;
    any_hit = 1'b0;
    for (int l = MaxCodeBits; l >= MinCodeBits; l--) begin
      if (avail[l] && entry_arr[l].hit) begin
        sel     = entry_arr[l];
        sel_len = LenW'(l);
        any_hit = 1'b1;
      end
    end
  end

  always_comb begin
    if (any_hit) begin
      kind = KindHit;
    end else if (held_q >= HeldW'(MaxCodeBits)) begin
      kind = KindInvalid;
    end else begin
      kind = KindPause;
    end
  end

  assign rem_held = held_q - HeldW'(sel_len);

  always_comb begin
    for (int i = 0; i < WindowBits; i++) begin
      keep_mask[i] = HeldW'(i) < rem_held;
    end
  end

  always_comb begin
    if (kind == KindInvalid) begin
      new_sym    = 8'h00;
      new_status = StatusInvalid;
    end else if (sel.is_end) begin
      new_sym    = end_marker_i;
      new_status = StatusEnd;
    end else begin
      new_sym    = sel.sym;
      new_status = StatusSymbol;
    end
  end

  assign out_free  = !out_valid_q || !out_stall_i;
  assign out_push  = pend_valid_q && (cmd_i.step || cmd_i.finish);
  assign push_last = cmd_i.finish;

  assign status_o.ended      = ended_q;
  assign status_o.cap_hit    = count_q == CountW'(ResultCap);
  assign status_o.kind       = kind;
  assign status_o.pend_valid = pend_valid_q;
  assign status_o.out_free   = out_free;

  // window and message state
  always_comb begin
    window_d     = window_q;
    held_d       = held_q;
    ended_d      = ended_q;
    pend_valid_d = pend_valid_q;
    if (cmd_i.load && !ended_q) begin
      window_d = {window_q[WindowBits-9:0], in_byte_i};
      held_d   = held_q + HeldW'(8);
    end
    if (cmd_i.step) begin
      pend_valid_d = 1'b1;
      if (kind == KindInvalid) begin
        window_d = '0;
        held_d   = '0;
      end else begin
        window_d = window_q & keep_mask;
        held_d   = rem_held;
        ended_d  = sel.is_end;
      end
    end
    if (cmd_i.finish) begin
      pend_valid_d = 1'b0;
      if (final_q) begin
        window_d = '0;
        held_d   = '0;
        ended_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q     <= '0;
      held_q       <= '0;
      ended_q      <= 1'b0;
      final_q      <= 1'b0;
      count_q      <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      window_q     <= window_d;
      held_q       <= held_d;
      ended_q      <= ended_d;
      pend_valid_q <= pend_valid_d;
      if (cmd_i.load) begin
        final_q <= final_byte_i;
        count_q <= '0;
      end else if (cmd_i.step) begin
        count_q <= count_q + CountW'(1);
      end
      if (out_push) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      pend_sym_q    <= new_sym;
      pend_status_q <= new_status;
    end
    if (out_push) begin
      out_sym_q    <= pend_sym_q;
      out_status_q <= pend_status_q;
      out_last_q   <= push_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign symbol_o      = out_sym_q;
  assign status_out_o  = out_status_q;
  assign last_of_run_o = out_last_q;

  `SHBD_ASSERT(a_held_range, held_q <= HeldW'(WindowBits), "bits held exceeds window")
  `SHBD_ASSERT(a_no_overwrite, !out_push || out_free, "output beat overwritten while stalled")
  `SHBD_ASSERT(a_count_cap, count_q <= CountW'(ResultCap), "result count beyond cap")
  `SHBD_ASSERT_NEXT(a_finish_flush, cmd_i.finish, !pend_valid_q, "pending beat left after run")
  `SHBD_ASSERT(a_step_needs_room, !cmd_i.step || !ended_q, "match step after end marker")

endmodule

[rtl/static_huffman_byte_decoder_core.sv]
// ----------------------------------------------------------------------------
// static_huffman_byte_decoder_core
// Static Huffman decoder over packed bytes with an APB end-marker register.
// ----------------------------------------------------------------------------
// Packed code bytes enter MSB first and are appended to an 18-bit window.
// Codes of 2 to 11 bits are matched against a fixed ROM, shortest length
// first; each match sends out one beat with its symbol. A byte occupies the
// block until its run closes, releasing 0 to 10 beats: a load step takes
// the byte, the match unit (one ROM lookup per code length) resolves one
// code per cycle while the output side does not stall, and a closing step
// releases the final beat with last_of_run set. A beat is held one step
// before it leaves so its last_of_run flag is known. The end-marker
// code emits the end_marker_symbol register with status end; bytes are then
// ignored until one with final_byte set. A final byte clears the window and
// drops leftover bits. Eleven or more unmatched bits give one beat with
// status invalid and symbol zero, and the window clears. Register 0 at
// byte address 0 holds end_marker_symbol (reset 4); write it only while idle.
// ----------------------------------------------------------------------------
module static_huffman_byte_decoder_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // byte input channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [7:0]                 in_byte_i,
  input  logic                       final_byte_i,
  // result channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [7:0]                 symbol_o,
  output logic [1:0]                 status_o,
  output logic                       last_of_run_o,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [shbd_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import shbd_pkg::*;

  logic [7:0] end_marker_sym_q;
  logic       reg_hit;
  logic       cfg_write;
  dp_cmd_t    cmd;
  dp_status_t dp_status;

  // register select: word index, byte offset ignored
  assign reg_hit   = paddr[AddrW-1:2] == RegEndMarker;
  assign cfg_write = psel && penable && pwrite;
  assign pready    = 1'b1;
  assign prdata    = reg_hit ? {24'h0, end_marker_sym_q} : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      end_marker_sym_q <= EndMarkerReset;
    end else begin
      if (cfg_write && reg_hit) begin
        end_marker_sym_q <= pwdata[7:0];
      end
    end
  end

  shbd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (dp_status),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  shbd_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .in_byte_i     (in_byte_i),
    .final_byte_i  (final_byte_i),
    .end_marker_i  (end_marker_sym_q),
    .out_stall_i   (out_stall_i),
    .status_o      (dp_status),
    .out_valid_o   (out_valid_o),
    .symbol_o      (symbol_o),
    .status_out_o  (status_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

[tb/tb_static_huffman_byte_decoder_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_static_huffman_byte_decoder_core
// Self-checking bench for the static Huffman byte decoder.
// A directed table covers reset behavior, byte extremes, the end code, bytes
// ignored after it and final bytes that drop leftover bits. Random
// well-formed code streams and raw noise bytes follow. Every accepted byte
// runs through a local decoder model. Each result beat is checked field by
// field against the oldest expected beat. The end-marker register is
// rewritten between phases and read back.
// ----------------------------------------------------------------------------
module tb_static_huffman_byte_decoder_core;
  import shbd_pkg::*;

  localparam logic [AddrW-1:0] EndMarkerAddr = {RegEndMarker, 2'b00};
  localparam int NumCodes = 71;
  localparam int EndRow   = 70;   // end code is the last row of the list
  localparam int NumProbes = 26;

  // one row of the code list: code bits right aligned
  typedef struct packed {
    logic [10:0] bits;
    logic [3:0]  len;
    logic [7:0]  sym;
    logic        is_end;
  } code_row_t;

  typedef struct packed {
    logic [7:0] sym;
    status_e    status;
    logic       last;
  } beat_t;

  // directed row; typed rows carry count beats of one symbol and status
  typedef struct packed {
    logic [7:0] data;
    logic       fin;
    logic       typed;
    logic [3:0] count;
    logic [7:0] sym;
    status_e    status;
  } probe_row_t;

  code_row_t code_list [NumCodes] = '{
    '{11'h000, 4'd2, " ", 1'b0}, '{11'h002, 4'd2, "0", 1'b0},
    '{11'h01A, 4'd5, 8'h0D, 1'b0}, '{11'h01B, 4'd5, 8'h0A, 1'b0},
    '{11'h00B, 4'd5, "i", 1'b0},
    '{11'h010, 4'd6, "p", 1'b0}, '{11'h011, 4'd6, "r", 1'b0},
    '{11'h014, 4'd6, "E", 1'b0}, '{11'h01C, 4'd6, "1", 1'b0},
    '{11'h01E, 4'd6, "m", 1'b0}, '{11'h01F, 4'd6, "a", 1'b0},
    '{11'h030, 4'd6, "t", 1'b0}, '{11'h031, 4'd6, "o", 1'b0},
    '{11'h032, 4'd6, "e", 1'b0}, '{11'h03F, 4'd6, "d", 1'b0},
    '{11'h03D, 4'd6, "n", 1'b0},
    '{11'h074, 4'd7, ">", 1'b0}, '{11'h075, 4'd7, "l", 1'b0},
    '{11'h076, 4'd7, "I", 1'b0}, '{11'h077, 4'd7, "u", 1'b0},
    '{11'h073, 4'd7, "4", 1'b0}, '{11'h071, 4'd7, "C", 1'b0},
    '{11'h079, 4'd7, "_", 1'b0}, '{11'h030, 4'd7, "9", 1'b0},
    '{11'h031, 4'd7, "D", 1'b0}, '{11'h02A, 4'd7, "2", 1'b0},
    '{11'h02B, 4'd7, "A", 1'b0}, '{11'h033, 4'd7, "T", 1'b0},
    '{11'h034, 4'd7, "f", 1'b0}, '{11'h035, 4'd7, "s", 1'b0},
    '{11'h037, 4'd7, "M", 1'b0}, '{11'h03B, 4'd7, "3", 1'b0},
    '{11'h0FB, 4'd8, ":", 1'b0}, '{11'h0F8, 4'd8, "h", 1'b0},
    '{11'h0F9, 4'd8, "8", 1'b0}, '{11'h0E0, 4'd8, "N", 1'b0},
    '{11'h0E1, 4'd8, "R", 1'b0}, '{11'h0E4, 4'd8, "B", 1'b0},
    '{11'h0E5, 4'd8, "v", 1'b0}, '{11'h0F0, 4'd8, "c", 1'b0},
    '{11'h049, 4'd8, "H", 1'b0}, '{11'h04C, 4'd8, "G", 1'b0},
    '{11'h04D, 4'd8, "y", 1'b0}, '{11'h04E, 4'd8, "L", 1'b0},
    '{11'h04F, 4'd8, "x", 1'b0}, '{11'h064, 4'd8, "w", 1'b0},
    '{11'h065, 4'd8, "U", 1'b0}, '{11'h06C, 4'd8, "S", 1'b0},
    '{11'h06D, 4'd8, "b", 1'b0}, '{11'h074, 4'd8, "5", 1'b0},
    '{11'h0CC, 4'd8, "z", 1'b0}, '{11'h0CD, 4'd8, "P", 1'b0},
    '{11'h0CF, 4'd8, "O", 1'b0},
    '{11'h090, 4'd9, "Z", 1'b0}, '{11'h091, 4'd9, "Y", 1'b0},
    '{11'h094, 4'd9, "Q", 1'b0}, '{11'h095, 4'd9, "K", 1'b0},
    '{11'h096, 4'd9, "X", 1'b0}, '{11'h097, 4'd9, "W", 1'b0},
    '{11'h0EA, 4'd9, "7", 1'b0}, '{11'h0EB, 4'd9, "k", 1'b0},
    '{11'h19D, 4'd9, "V", 1'b0}, '{11'h1E2, 4'd9, "j", 1'b0},
    '{11'h1E3, 4'd9, "F", 1'b0},
    '{11'h3E8, 4'd10, "g", 1'b0}, '{11'h3E9, 4'd10, "6", 1'b0},
    '{11'h3EA, 4'd10, "J", 1'b0}, '{11'h3EB, 4'd10, "q", 1'b0},
    '{11'h338, 4'd10, "-", 1'b0},
    '{11'h672, 4'd11, ".", 1'b0}, '{11'h673, 4'd11, 8'h00, 1'b1}
  };

  // Directed bytes. The code set is complete, so an unmatched run of
  // eleven bits never forms; the invalid path stays in the model only.
  probe_row_t probe_table [NumProbes] = '{
    '{8'h00, 1'b0, 1'b1, 4'd4, " ", StatusSymbol},   // four spaces from reset
    '{8'hAA, 1'b0, 1'b1, 4'd4, "0", StatusSymbol},   // four zeros
    '{8'h55, 1'b0, 1'b0, 4'd0, 8'h00, StatusSymbol},
    '{8'hFF, 1'b0, 1'b0, 4'd0, 8'h00, StatusSymbol},
    '{8'hFF, 1'b0, 1'b0, 4'd0, 8'h00, StatusSymbol},
    '{8'h80, 1'b1, 1'b0, 4'd0, 8'h00, StatusSymbol},
    '{8'h01, 1'b0, 1'b0, 4'd0, 8'h00, StatusSymbol},
    '{8'h7F, 1'b1, 1'b0, 4'd0, 8'h00, StatusSymbol},
    '{8'hCE, 1'b0, 1'b1, 4'd0, 8'h00, StatusSymbol}, // prefix of end code
    '{8'h60, 1'b0, 1'b1, 4'd1, EndMarkerReset, StatusEnd},
    '{8'h00, 1'b0, 1'b1, 4'd0, 8'h00, StatusSymbol}, // ignored after end
    '{8'hFF, 1'b0, 1'b1, 4'd0, 8'h00, StatusSymbol},
    '{8'h00, 1'b1, 1'b1, 4'd0, 8'h00, StatusSymbol}, // final clears end
    '{8'h00, 1'b0, 1'b1, 4'd4, " ", StatusSymbol},
    '{8'hCE, 1'b1, 1'b1, 4'd0, 8'h00, StatusSymbol}, // leftover dropped
    '{8'hAA, 1'b0, 1'b1, 4'd4, "0", StatusSymbol},
    '{8'hFA, 1'b0, 1'b0, 4'd0, 8'h00, StatusSymbol}, // ten-bit code
    '{8'h00, 1'b0, 1'b0, 4'd0, 8'h00, StatusSymbol},
    '{8'hCE, 1'b0, 1'b0, 4'd0, 8'h00, StatusSymbol}, // eleven-bit '.'
    '{8'h40, 1'b0, 1'b0, 4'd0, 8'h00, StatusSymbol},
    '{8'hCE, 1'b0, 1'b0, 4'd0, 8'h00, StatusSymbol},
    '{8'h7F, 1'b1, 1'b0, 4'd0, 8'h00, StatusSymbol}, // final drops leftover bits
    '{8'h00, 1'b0, 1'b1, 4'd4, " ", StatusSymbol},
    '{8'h9D, 1'b0, 1'b0, 4'd0, 8'h00, StatusSymbol},
    '{8'hC0, 1'b1, 1'b0, 4'd0, 8'h00, StatusSymbol},
    '{8'hFF, 1'b1, 1'b0, 4'd0, 8'h00, StatusSymbol}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  in_byte_i;
  logic        final_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  symbol_o;
  logic [1:0]  status_o;
  logic        last_of_run_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [AddrW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // row info travels with the payload so the scoreboard sees it on accept
  logic        row_typed;
  logic [3:0]  row_count;
  logic [7:0]  row_sym;
  status_e     row_status;

  // decoder model state
  logic [31:0] pred_window;
  int          pred_held;
  logic        pred_ended;
  logic [7:0]  pred_end_sym;

  beat_t       run_beats [$];
  beat_t       beats_due [$];
  int          errors;
  int          items_sent;
  bit          gaps_on;
  bit          stall_on;
  bit          long_hold;

  static_huffman_byte_decoder_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_byte_i     (in_byte_i),
    .final_byte_i  (final_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .symbol_o      (symbol_o),
    .status_o      (status_o),
    .last_of_run_o (last_of_run_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Index of the matching code row, -1 if none.
  function automatic int code_find(input logic [31:0] val, input int len);
    int hit;
    hit = -1;
    for (int r = 0; r < NumCodes; r++) begin
      if (hit < 0 && int'(code_list[r].len) == len && 32'(code_list[r].bits) == val) begin
        hit = r;
      end
    end
    return hit;
  endfunction

  // Decoder model: appends one byte to the window and fills run_beats with
  // the beats it releases, shortest code length tried first.
  function automatic void decode_byte(input logic [7:0] data, input logic fin);
    int    hit;
    int    used;
    bit    paused;
    bit    stop;
    beat_t b;
    run_beats.delete();
    if (!pred_ended) begin
      pred_held   = pred_held + 8;
      pred_window = ((pred_window << 8) | 32'(data)) & ((32'd1 << pred_held) - 1);
      stop = 1'b0;
      while (!stop && !pred_ended && run_beats.size() < ResultCap) begin
        hit    = -1;
        used   = 0;
        paused = 1'b0;
        for (int l = MinCodeBits; l <= MaxCodeBits; l++) begin
          if (hit < 0 && !paused) begin
            if (pred_held < l) begin
              paused = 1'b1;
            end else begin
              hit = code_find((pred_window >> (pred_held - l)) & ((32'd1 << l) - 1), l);
              if (hit >= 0) used = l;
            end
          end
        end
        b.last = 1'b0;
        if (hit >= 0) begin
          pred_held   = pred_held - used;
          pred_window = pred_window & ((32'd1 << pred_held) - 1);
          if (code_list[hit].is_end) begin
            b.sym      = pred_end_sym;
            b.status   = StatusEnd;
            pred_ended = 1'b1;
          end else begin
            b.sym    = code_list[hit].sym;
            b.status = StatusSymbol;
          end
          run_beats.push_back(b);
        end else if (paused) begin
          stop = 1'b1;
        end else begin
          // eleven bits with no code: one invalid beat, window dropped
          b.sym       = 8'h00;
          b.status    = StatusInvalid;
          run_beats.push_back(b);
          pred_window = '0;
          pred_held   = 0;
          stop        = 1'b1;
        end
      end
    end
    if (run_beats.size() > 0) run_beats[run_beats.size() - 1].last = 1'b1;
    if (fin) begin
      pred_window = '0;
      pred_held   = 0;
      pred_ended  = 1'b0;
    end
  endfunction

  // Scoreboard: result beats first, then the byte accepted at this edge.
  always @(posedge clk_i) begin : scoreboard
    beat_t due;
    beat_t b;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (beats_due.size() == 0) begin
          errors++;
          $display("%0t: expected no beat, actual sym=%h status=%0d last=%b", $time,
                   symbol_o, status_o, last_of_run_o);
        end else begin
          due = beats_due.pop_front();
          if (symbol_o !== due.sym || status_o !== due.status ||
              last_of_run_o !== due.last) begin
            errors++;
            if (symbol_o !== due.sym)
              $display("%0t: symbol expected %h actual %h", $time, due.sym, symbol_o);
            if (status_o !== due.status)
              $display("%0t: status expected %0d actual %0d", $time, due.status,
                       status_o);
            if (last_of_run_o !== due.last)
              $display("%0t: last_of_run expected %b actual %b", $time, due.last,
                       last_of_run_o);
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        // model always advances; typed rows replace its beats with the table's
        decode_byte(in_byte_i, final_byte_i);
        if (row_typed) begin
          run_beats.delete();
          for (int k = 0; k < row_count; k++) begin
            b.sym    = row_sym;
            b.status = row_status;
            b.last   = (k == row_count - 1);
            run_beats.push_back(b);
          end
        end
        foreach (run_beats[k]) beats_due.push_back(run_beats[k]);
      end
    end
  end

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin
    out_stall_i = 1'b0;
    @(negedge clk_i);
    forever begin
      if (long_hold) begin
        out_stall_i <= 1'b1;
        repeat (90) @(negedge clk_i);
        long_hold = 1'b0;
      end else if (stall_on && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 17)) @(negedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
      end
    end
  end

  // Offer one byte from a falling edge; returns at the falling edge after
  // the beat was taken.
  task automatic send_byte(input logic [7:0] data, input logic fin, input logic typed,
                           input logic [3:0] count, input logic [7:0] sym,
                           input status_e status);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    in_byte_i    <= data;
    final_byte_i <= fin;
    row_typed    <= typed;
    row_count    <= count;
    row_sym      <= sym;
    row_status   <= status;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Sender pauses until every expected beat is out, then allows the block
  // to finish a byte that releases nothing.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (beats_due.size() != 0) @(negedge clk_i);
    repeat (16) @(negedge clk_i);
  endtask

  task automatic reg_write(input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= EndMarkerAddr;
    pwdata  <= {16'($urandom_range(0, 16'hFFFF)), 8'($urandom_range(0, 255)), value};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    pred_end_sym = value;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic reg_check();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= EndMarkerAddr;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata[7:0] !== pred_end_sym) begin
      errors++;
      $display("%0t: end_marker_symbol read expected %h actual %h", $time,
               pred_end_sym, prdata[7:0]);
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // One well-formed message: random symbols, usually the end code, padding,
  // sometimes trailing bytes that the block must ignore; the last byte is usually final.
  task automatic send_message();
    bit         stream [$];
    int         nsym;
    int         idx;
    int         extra;
    int         nbytes;
    bit         with_end;
    logic [7:0] data;
    nsym = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 8);
    for (int k = 0; k < nsym; k++) begin
      idx = $urandom_range(0, EndRow - 1);
      for (int j = int'(code_list[idx].len) - 1; j >= 0; j--)
        stream.push_back(code_list[idx].bits[j]);
    end
    with_end = ($urandom_range(0, 4) != 0);
    if (with_end) begin
      for (int j = int'(code_list[EndRow].len) - 1; j >= 0; j--)
        stream.push_back(code_list[EndRow].bits[j]);
    end
    while (stream.size() % 8 != 0) stream.push_back(1'($urandom_range(0, 1)));
    nbytes = stream.size() / 8;
    extra  = (with_end && $urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
    repeat (extra * 8) stream.push_back(1'($urandom_range(0, 1)));
    items_sent += nbytes + extra;
    while (stream.size() > 0) begin
      repeat (8) data = {data[6:0], stream.pop_front()};
      send_byte(data, stream.size() == 0 && $urandom_range(0, 9) != 0, 1'b0, 4'd0,
                8'h00, StatusSymbol);
    end
  endtask

  task automatic random_run(input int target);
    while (items_sent < target) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0, 1'b0, 4'd0,
                    8'h00, StatusSymbol);
          items_sent++;
        end
      end else begin
        send_message();
      end
    end
  endtask

  // Hard stop in case the block hangs.
  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_byte_i    = 8'h00;
    final_byte_i = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    row_typed    = 1'b0;
    row_count    = 4'd0;
    row_sym      = 8'h00;
    row_status   = StatusSymbol;
    pred_window  = '0;
    pred_held    = 0;
    pred_ended   = 1'b0;
    pred_end_sym = EndMarkerReset;
    errors       = 0;
    items_sent   = 0;
    gaps_on      = 1'b1;
    stall_on     = 1'b1;
    long_hold    = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset value of the register, then the directed table
    reg_check();
    foreach (probe_table[i])
      send_byte(probe_table[i].data, probe_table[i].fin, probe_table[i].typed,
                probe_table[i].count, probe_table[i].sym, probe_table[i].status);

    // lowest end-marker value
    drain();
    reg_write(8'h00);
    reg_check();
    random_run(80);

    // highest value; receiver holds off while bytes keep coming
    drain();
    reg_write(8'hFF);
    reg_check();
    gaps_on   = 1'b0;
    long_hold = 1'b1;
    repeat (16) begin
      send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, 4'd0, 8'h00, StatusSymbol);
      items_sent++;
    end
    gaps_on = 1'b1;
    random_run(170);

    // random value, no idling on either side
    drain();
    reg_write(8'($urandom_range(1, 254)));
    reg_check();
    gaps_on  = 1'b0;
    stall_on = 1'b0;
    random_run(250);

    in_valid_i <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[static_huffman_byte_decoder_core.f]
+incdir+rtl
rtl/shbd_pkg.sv
rtl/shbd_ctrl.sv
rtl/shbd_dp.sv
rtl/static_huffman_byte_decoder_core.sv
tb/tb_static_huffman_byte_decoder_core.sv
